/* hw/rtl/cpp_pkg.sv */
`default_nettype none
package cpp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int SLOPE_MARK     = 100;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
    logic                      path_end;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] kept_x;
    logic signed [FIELD_W-1:0] kept_y;
    logic signed [FIELD_W-1:0] kept_z;
    logic                      final_point;
    logic                      overflowed;
  } out_word_t;

  typedef enum logic [1:0] {
    AXIS_UNDEF = 2'd0,
    AXIS_X     = 2'd1,
    AXIS_Z     = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    RD_B = 2'd0,
    RD_J = 2'd1,
    RD_I = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic    load;
    logic    dd_init;
    logic    dd_wr;
    rd_src_t rd_src;
    logic    scan_y;
    logic    j_inc;
    logic    set_e;
    logic    i_from_b;
    logic    emit_rd;
    logic    i_inc;
    logic    open_init;
    logic    e1;
    logic    e2;
    logic    e3;
    logic    rewind;
    logic    step;
    logic    next_run;
    logic    flush;
  } dp_cmd_t;

  typedef struct packed {
    logic dd_last;
    logic j_eq_n;
    logic y_diff;
    logic short_run;
    logic i_last;
    logic end_last;
    logic e_eq_n;
    logic rewind;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/cpp_ram.sv */
`default_nettype none
module cpp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/cpp_ctrl.sv */
`default_nettype none
module cpp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_path_end,
  output logic                  in_ready,
  output cpp_pkg::dp_cmd_t      cmd,
  input  wire cpp_pkg::dp_sts_t sts
);

  typedef enum logic [18:0] {
    S_LOAD   = 19'h00001,
    S_DRD    = 19'h00002,
    S_DWR    = 19'h00004,
    S_SRD    = 19'h00008,
    S_SY     = 19'h00010,
    S_SCHK   = 19'h00020,
    S_SCMP   = 19'h00040,
    S_RUNSEL = 19'h00080,
    S_LRD    = 19'h00100,
    S_LEM    = 19'h00200,
    S_PRD0   = 19'h00400,
    S_PINIT  = 19'h00800,
    S_PRD    = 19'h01000,
    S_E1     = 19'h02000,
    S_E2     = 19'h04000,
    S_E3     = 19'h08000,
    S_E4     = 19'h10000,
    S_NEXT   = 19'h20000,
    S_FLUSH  = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_src = cpp_pkg::RD_I;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_path_end) begin
            cmd.dd_init = 1'b1;
            state_nxt   = S_DRD;
          end
        end
      end
      S_DRD: state_nxt = S_DWR;
      S_DWR: begin
        cmd.dd_wr = 1'b1;
        state_nxt = sts.dd_last ? S_SRD : S_DRD;
      end
      S_SRD: begin
        cmd.rd_src = cpp_pkg::RD_B;
        state_nxt  = S_SY;
      end
      S_SY: begin
        cmd.scan_y = 1'b1;
        state_nxt  = S_SCHK;
      end
      S_SCHK: begin
        if (sts.j_eq_n) begin
          cmd.set_e = 1'b1;
          state_nxt = S_RUNSEL;
        end else begin
          cmd.rd_src = cpp_pkg::RD_J;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.y_diff) begin
          cmd.set_e = 1'b1;
          state_nxt = S_RUNSEL;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_RUNSEL: begin
        if (sts.short_run) begin
          cmd.i_from_b = 1'b1;
          state_nxt    = S_LRD;
        end else begin
          state_nxt = S_PRD0;
        end
      end
      S_LRD: state_nxt = S_LEM;
      S_LEM: begin
        if (sts.out_free) begin
          cmd.emit_rd = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = sts.i_last ? S_NEXT : S_LRD;
        end
      end
      S_PRD0: begin
        cmd.rd_src = cpp_pkg::RD_B;
        state_nxt  = S_PINIT;
      end
      S_PINIT: begin
        if (sts.out_free) begin
          cmd.open_init = 1'b1;
          state_nxt     = S_PRD;
        end
      end
      S_PRD: state_nxt = S_E1;
      S_E1: begin
        cmd.e1    = 1'b1;
        state_nxt = S_E2;
      end
      S_E2: begin
        cmd.e2    = 1'b1;
        state_nxt = S_E3;
      end
      S_E3: begin
        cmd.e3    = 1'b1;
        state_nxt = S_E4;
      end
      S_E4: begin
        if (sts.rewind) begin
          if (sts.out_free) begin
            cmd.rewind = 1'b1;
            state_nxt  = sts.end_last ? S_NEXT : S_PRD;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_NEXT: begin
        cmd.next_run = 1'b1;
        state_nxt    = sts.e_eq_n ? S_FLUSH : S_SRD;
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/cpp_dp.sv */
`default_nettype none
module cpp_dp #(
  parameter int MAX_POINTS = cpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cpp_pkg::COORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cpp_pkg::dp_cmd_t  cmd,
  output cpp_pkg::dp_sts_t       sts,
  input  wire cpp_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cpp_pkg::out_word_t     out_word
);

  localparam int C  = COORD_BITS;
  localparam int PW = 3 * C;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = $clog2(MAX_POINTS + 1);
  localparam int SW = (C + 3 > 9) ? C + 3 : 9;
  localparam int FW = cpp_pkg::FIELD_W;

  // point word: x high, y middle, z low
  logic [PW-1:0] in_pt, st_rd, run_rd;
  logic [31:0]   ix, iy, iz;

  logic [IW-1:0] count_r, j_r, n_r, b_r, e_r, i_r, end_r;
  logic          ovf_r;
  logic [PW-1:0] last_r, s_r, p_r, c_r, endp_r, pend_r;
  logic          pend_v_r, out_v_r;
  logic [C-1:0]  y0_r;
  cpp_pkg::out_word_t out_r;

  logic signed [SW-1:0] up_num_r, up_den_r, lo_num_r, lo_den_r;
  logic signed [SW-1:0] den_r, cnum_r;
  logic                 adv_r;
  cpp_pkg::axis_t       axis_r;

  logic          st_we, run_we;
  logic [IW-1:0] run_ra;

  assign ix    = {{(32-FW){1'b0}}, in_word.point_x};
  assign iy    = {{(32-FW){1'b0}}, in_word.point_y};
  assign iz    = {{(32-FW){1'b0}}, in_word.point_z};
  assign in_pt = {ix[C-1:0], iy[C-1:0], iz[C-1:0]};

  assign st_we  = cmd.load && (count_r != IW'(MAX_POINTS));
  assign run_we = cmd.dd_wr && ((n_r == '0) || (st_rd != last_r));

  always_comb begin
    case (cmd.rd_src)
      cpp_pkg::RD_B: run_ra = b_r;
      cpp_pkg::RD_J: run_ra = j_r;
      default:       run_ra = i_r;
    endcase
  end

  cpp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_pt),
    .raddr (j_r[AW-1:0]),
    .rdata (st_rd)
  );

  cpp_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_run (
    .clk   (clk),
    .we    (run_we),
    .waddr (n_r[AW-1:0]),
    .wdata (st_rd),
    .raddr (run_ra[AW-1:0]),
    .rdata (run_rd)
  );

  // offsets of the current point from the segment start
  logic signed [C:0] dx, dz, pdx, pdz, cd, pd, dmaj, dmin;
  logic        [C:0] adx, adz, acd, apd, amaj;
  logic              ax_x, adv, flip;
  cpp_pkg::axis_t    ax;
  logic signed [SW-1:0] min_sw, cnum, den;

  function automatic logic signed [C:0] diff(input logic [C-1:0] a, input logic [C-1:0] b);
    diff = $signed({a[C-1], a}) - $signed({b[C-1], b});
  endfunction

  function automatic logic [C:0] mag(input logic signed [C:0] v);
    mag = v[C] ? $unsigned(-v) : $unsigned(v);
  endfunction

  always_comb begin
    dx     = diff(run_rd[PW-1:2*C], s_r[PW-1:2*C]);
    dz     = diff(run_rd[C-1:0], s_r[C-1:0]);
    pdx    = diff(p_r[PW-1:2*C], s_r[PW-1:2*C]);
    pdz    = diff(p_r[C-1:0], s_r[C-1:0]);
    adx    = mag(dx);
    adz    = mag(dz);
    ax_x   = (adx >= adz);
    ax     = ax_x ? cpp_pkg::AXIS_X : cpp_pkg::AXIS_Z;
    cd     = ax_x ? dx : dz;
    pd     = ax_x ? pdx : pdz;
    acd    = mag(cd);
    apd    = mag(pd);
    adv    = (acd > apd);
    dmaj   = ax_x ? dx : dz;
    dmin   = ax_x ? dz : dx;
    amaj   = mag(dmaj);
    min_sw = SW'(dmin);
    cnum   = min_sw <<< 1;
    den    = $signed(SW'(amaj)) <<< 1;
    flip   = (axis_r != ax) && (axis_r != cpp_pkg::AXIS_UNDEF) && (dx[C] != dz[C]);
  end

  // exact slope compares by cross products
  logic signed [SW-1:0]   hi_num, lo_num;
  logic signed [2*SW-1:0] m_hu0, m_hu1, m_ll0, m_ll1;
  logic signed [2*SW-1:0] m_cl0, m_cl1, m_uc0, m_uc1, m_ul0, m_ul1;
  logic                   in_centre;

  assign hi_num = cnum_r + SW'(1);
  assign lo_num = cnum_r - SW'(1);
  assign m_hu0  = hi_num * up_den_r;
  assign m_hu1  = up_num_r * den_r;
  assign m_ll0  = lo_num_r * den_r;
  assign m_ll1  = lo_num * lo_den_r;
  assign m_cl0  = cnum_r * lo_den_r;
  assign m_cl1  = lo_num_r * den_r;
  assign m_uc0  = up_num_r * den_r;
  assign m_uc1  = cnum_r * up_den_r;
  assign m_ul0  = up_num_r * lo_den_r;
  assign m_ul1  = lo_num_r * up_den_r;
  assign in_centre = !(m_cl0 < m_cl1) && !(m_uc0 < m_uc1);

  // emission: the newest kept point waits in pend so the last one can be marked
  logic          emit_any;
  logic [PW-1:0] emit_pt;
  logic [31:0]   ox, oy, oz;

  assign emit_any = cmd.emit_rd || cmd.open_init || cmd.rewind;
  assign emit_pt  = cmd.rewind ? endp_r : run_rd;
  assign ox = 32'(pend_r[PW-1:2*C]);
  assign oy = 32'(pend_r[2*C-1:C]);
  assign oz = 32'(pend_r[C-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      axis_r   <= cpp_pkg::AXIS_UNDEF;
    end else begin
      if ((emit_any && pend_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.load) begin
        if (st_we) begin
          count_r <= count_r + IW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (emit_any) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.flush) begin
        pend_v_r <= 1'b0;
        count_r  <= '0;
        ovf_r    <= 1'b0;
      end
      if (cmd.open_init || cmd.rewind) begin
        axis_r <= cpp_pkg::AXIS_UNDEF;
      end else if (cmd.e1 && adv) begin
        axis_r <= ax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dd_init) begin
      j_r <= '0;
      n_r <= '0;
      b_r <= '0;
    end
    if (cmd.dd_wr) begin
      j_r <= j_r + IW'(1);
      if (run_we) begin
        n_r    <= n_r + IW'(1);
        last_r <= st_rd;
      end
    end
    if (cmd.scan_y) begin
      y0_r <= run_rd[2*C-1:C];
      j_r  <= b_r + IW'(1);
    end
    if (cmd.j_inc) begin
      j_r <= j_r + IW'(1);
    end
    if (cmd.set_e) begin
      e_r <= j_r;
    end
    if (cmd.i_from_b) begin
      i_r <= b_r;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + IW'(1);
    end
    if (cmd.next_run) begin
      b_r <= e_r;
    end
    if (emit_any) begin
      pend_r <= emit_pt;
      if (pend_v_r) begin
        out_r.kept_x      <= ox[FW-1:0];
        out_r.kept_y      <= oy[FW-1:0];
        out_r.kept_z      <= oz[FW-1:0];
        out_r.final_point <= 1'b0;
        out_r.overflowed  <= ovf_r;
      end
    end
    if (cmd.flush) begin
      out_r.kept_x      <= ox[FW-1:0];
      out_r.kept_y      <= oy[FW-1:0];
      out_r.kept_z      <= oz[FW-1:0];
      out_r.final_point <= 1'b1;
      out_r.overflowed  <= ovf_r;
    end
    // open a segment at a point: bounds back to the unbounded markers
    if (cmd.open_init || cmd.rewind) begin
      s_r      <= emit_pt;
      p_r      <= emit_pt;
      up_num_r <= SW'(cpp_pkg::SLOPE_MARK);
      up_den_r <= SW'(1);
      lo_num_r <= -SW'(cpp_pkg::SLOPE_MARK);
      lo_den_r <= SW'(1);
    end
    if (cmd.open_init) begin
      endp_r <= run_rd;
      end_r  <= b_r;
      i_r    <= b_r + IW'(1);
    end
    if (cmd.rewind) begin
      i_r <= end_r + IW'(1);
    end
    if (cmd.e1) begin
      c_r    <= run_rd;
      adv_r  <= adv;
      den_r  <= den;
      cnum_r <= cnum;
      if (adv && flip) begin
        up_num_r <= -lo_num_r;
        up_den_r <= lo_den_r;
        lo_num_r <= -up_num_r;
        lo_den_r <= up_den_r;
      end
    end
    if (cmd.e2 && adv_r) begin
      if (m_hu0 < m_hu1) begin
        up_num_r <= hi_num;
        up_den_r <= den_r;
      end
      if (m_ll0 < m_ll1) begin
        lo_num_r <= lo_num;
        lo_den_r <= den_r;
      end
    end
    if (cmd.e3 && adv_r && in_centre) begin
      end_r  <= i_r;
      endp_r <= c_r;
    end
    if (cmd.step) begin
      p_r <= c_r;
      i_r <= i_r + IW'(1);
    end
  end

  always_comb begin
    sts.dd_last   = ((j_r + IW'(1)) == count_r);
    sts.j_eq_n    = (j_r == n_r);
    sts.y_diff    = (run_rd[2*C-1:C] != y0_r);
    sts.short_run = ((e_r - b_r) <= IW'(2));
    sts.i_last    = ((i_r + IW'(1)) == e_r);
    sts.end_last  = ((end_r + IW'(1)) == e_r);
    sts.e_eq_n    = (e_r == n_r);
    sts.rewind    = (m_ul0 < m_ul1) || !adv_r || sts.i_last;
    sts.out_free  = !out_v_r || out_ready;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

/* hw/rtl/collinear_path_point_pruner.sv */
`default_nettype none
// Collinear path point pruner. Points (x, elevation, z) load one word per cycle into a
// MAX_POINTS-entry store until a word with path_end; points past capacity are dropped and
// every result of that path carries overflowed. After path_end the input stalls while the
// block copies the store into a run buffer without consecutive duplicates (a read and a
// write step per stored point), splits the path where elevation changes (a check and a
// compare step per point scanned), and prunes each run of three or more points with a
// reverse Bresenham slope interval: every visited point takes one run-buffer read, three
// compare steps and a decision step, and each rewind revisits the points after the last
// good segment end. Runs of one or two points emit with a run-buffer read and an emit
// step per point. Kept points leave through a one-deep output register; the newest kept
// point is held back one step so the last one can carry final_point. Output coordinates
// are COORD_BITS wide, zero-extended to the 16-bit fields. Input is taken again once the
// final word has moved into the output register.
module collinear_path_point_pruner #(
  parameter int MAX_POINTS = cpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cpp_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cpp_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cpp_pkg::out_word_t      out_word
);

  cpp_pkg::dp_cmd_t cmd;
  cpp_pkg::dp_sts_t sts;

  // sequence the load, dedup, scan and prune phases
  cpp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_path_end (in_word.path_end),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // hold the store, the run buffer, the slope interval and the output register
  cpp_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* hw/rtl/cpp_chk.sv */
`default_nettype none
module cpp_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire cpp_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire cpp_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_word.path_end |=> !in_ready)
    else $error("input taken while the path is being pruned");

endmodule

bind collinear_path_point_pruner cpp_chk u_chk (.*);
`default_nettype wire
